// ----- design/digital_root_histogram_top_assert.svh -----
// Assertion macros for the digital root histogram checker.
`ifndef DIGITAL_ROOT_HISTOGRAM_TOP_ASSERT_SVH
`define DIGITAL_ROOT_HISTOGRAM_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DRH_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define DRH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ----- design/drh_pkg.sv -----
// Package: types and constants for the digital root histogram block.
`default_nettype none
package drh_pkg;

   localparam int CHAR_WIDTH      = 8;
   localparam int BASE_WIDTH      = 7;
   localparam int ROOT_WIDTH      = 6;
   localparam int COUNT_WIDTH     = 32;
   localparam int ACCUM_WIDTH     = 31;
   localparam int MAX_BASE        = 64;
   localparam int HIST_ADDR_WIDTH = $clog2(MAX_BASE);
   localparam int BIT_CNT_WIDTH   = $clog2(ACCUM_WIDTH);
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [ACCUM_WIDTH-1:0] ACCUM_MAX = {ACCUM_WIDTH{1'b1}};
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [BASE_WIDTH-1:0]  BASE_RESET = BASE_WIDTH'(10);
   localparam logic [BASE_WIDTH-1:0]  BASE_MIN   = BASE_WIDTH'(2);
   localparam logic [BASE_WIDTH-1:0]  BASE_LIMIT = BASE_WIDTH'(MAX_BASE);

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE = 8'h39;

   // Register word index (paddr[2])
   localparam logic REG_BASE_SIZE = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic req_ready;
      logic div_step;
      logic ram_re;
      logic commit;
   } ctrl_type;

   // Saturating increment of a histogram or total count
   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      sat_inc = (v == COUNT_MAX) ? v : v + COUNT_WIDTH'(1);
   endfunction

endpackage
`default_nettype wire

// ----- design/drh_req_if.sv -----
// Interface: input character channel.
`default_nettype none
interface drh_req_if;
   logic                             valid;
   logic                             ready;
   logic [drh_pkg::CHAR_WIDTH-1:0]   char_in;

   modport source (output valid, output char_in, input ready);
   modport sink   (input valid, input char_in, output ready);
endinterface
`default_nettype wire

// ----- design/drh_rsp_if.sv -----
// Interface: result channel (root and counts).
`default_nettype none
interface drh_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [drh_pkg::ROOT_WIDTH-1:0]   root;
   logic [drh_pkg::COUNT_WIDTH-1:0]  root_count;
   logic [drh_pkg::COUNT_WIDTH-1:0]  total_count;

   modport source (output valid, output root, output root_count, output total_count,
                   input ready);
   modport sink   (input valid, input root, input root_count, input total_count,
                   output ready);
endinterface
`default_nettype wire

// ----- design/drh_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module drh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ----- design/digital_root_histogram_top.sv -----
// Top level: digit stream to digital root histogram.
//
//   channel   dir   handshake               beat contents
//   req_chan  in    valid/ready             char_in
//   rsp_chan  out   valid/ready             root, root_count, total_count
//   apb       in    psel/penable, pready=1  base_size at word 0
//
// A digit beat is folded into the accumulator as it is accepted. A delimiter is
// accepted, then runs the shared compare-subtract unit (one remainder bit per
// cycle), one histogram RAM read and one update; no new character is taken until
// the update is done. The update stalls while a result beat is still waiting on
// rsp_chan. Reset clears the bins at once through per-bin valid bits, so no clearing pass runs.
`default_nettype none
module digital_root_histogram_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   drh_req_if.sink                                req_chan,
   drh_rsp_if.source                              rsp_chan,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [drh_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [drh_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output      logic [drh_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output      logic                              pready
);

   localparam int AW = drh_pkg::ACCUM_WIDTH;
   localparam int RW = drh_pkg::ROOT_WIDTH;
   localparam int CW = drh_pkg::COUNT_WIDTH;
   localparam int BW = drh_pkg::BASE_WIDTH;
   localparam int NW = drh_pkg::BIT_CNT_WIDTH;

   drh_pkg::state_type state_ff, state_in;
   drh_pkg::ctrl_type  ctrl;

   logic [BW-1:0]                 base_ff;
   logic [AW-1:0]                 accum_ff;
   logic [AW-1:0]                 dvd_ff;
   logic [RW-1:0]                 rem_ff;
   logic [RW-1:0]                 mod_ff;
   logic                          zero_ff;
   logic [NW-1:0]                 cnt_ff;
   logic [RW-1:0]                 root_ff;
   logic [drh_pkg::MAX_BASE-1:0]  bin_valid_ff;
   logic [CW-1:0]                 total_ff;
   logic                          rsp_valid_ff;
   logic [RW-1:0]                 rsp_root_ff;
   logic [CW-1:0]                 rsp_root_count_ff;
   logic [CW-1:0]                 rsp_total_ff;

   logic                          req_fire;
   logic                          is_digit;
   logic [3:0]                    digit;
   logic [AW+3:0]                 accum_sum;
   logic [AW-1:0]                 accum_next;
   logic [BW-1:0]                 eff_base;
   logic [RW:0]                   trial;
   logic [RW-1:0]                 rem_next;
   logic                          out_free;
   logic                          csr_write;
   logic [CW-1:0]                 ram_rdata;
   logic [CW-1:0]                 bin_cur;
   logic [CW-1:0]                 bin_new;

   // Input decode
   assign req_fire = req_chan.valid && req_chan.ready;
   assign is_digit = (req_chan.char_in >= drh_pkg::CHAR_ZERO) &&
                     (req_chan.char_in <= drh_pkg::CHAR_NINE);
   assign digit    = 4'(req_chan.char_in - drh_pkg::CHAR_ZERO);

   // accum*10 + digit, saturating
   always_comb begin
      accum_sum = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0} + (AW+4)'(digit);
      if (accum_sum > (AW+4)'(drh_pkg::ACCUM_MAX)) begin
         accum_next = drh_pkg::ACCUM_MAX;
      end else begin
         accum_next = accum_sum[AW-1:0];
      end
   end

   // Base clamped to 2..MAX_BASE
   always_comb begin
      if (base_ff < drh_pkg::BASE_MIN) begin
         eff_base = drh_pkg::BASE_MIN;
      end else if (base_ff > drh_pkg::BASE_LIMIT) begin
         eff_base = drh_pkg::BASE_LIMIT;
      end else begin
         eff_base = base_ff;
      end
   end

   // Shared compare-subtract: one restoring remainder bit
   assign trial = {rem_ff, dvd_ff[AW-1]};
   always_comb begin
      if (trial >= {1'b0, mod_ff}) begin
         rem_next = RW'(trial - {1'b0, mod_ff});
      end else begin
         rem_next = trial[RW-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         drh_pkg::ST_IDLE: begin
            if (req_fire && !is_digit) begin
               state_in = drh_pkg::ST_DIVIDE;
            end
         end
         drh_pkg::ST_DIVIDE: begin
            if (cnt_ff == '0) begin
               state_in = drh_pkg::ST_LOOKUP;
            end
         end
         drh_pkg::ST_LOOKUP: state_in = drh_pkg::ST_UPDATE;
         drh_pkg::ST_UPDATE: begin
            if (out_free) begin
               state_in = drh_pkg::ST_IDLE;
            end
         end
         default: state_in = drh_pkg::ST_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         drh_pkg::ST_IDLE:   ctrl.req_ready = 1'b1;
         drh_pkg::ST_DIVIDE: ctrl.div_step  = 1'b1;
         drh_pkg::ST_LOOKUP: ctrl.ram_re    = 1'b1;
         drh_pkg::ST_UPDATE: ctrl.commit    = out_free;
         default:            ctrl = '0;
      endcase
   end

   assign req_chan.ready = ctrl.req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= drh_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Histogram storage; an unwritten bin reads as zero
   drh_ram #(
      .WIDTH (CW),
      .DEPTH (drh_pkg::MAX_BASE)
   ) u_hist (
      .clock (clock),
      .we    (ctrl.commit),
      .waddr (root_ff),
      .wdata (bin_new),
      .re    (ctrl.ram_re),
      .raddr (root_ff),
      .rdata (ram_rdata)
   );

   assign bin_cur = bin_valid_ff[root_ff] ? ram_rdata : '0;
   assign bin_new = drh_pkg::sat_inc(bin_cur);

   // Accumulator and divider datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= '0;
      end else if (req_fire) begin
         if (is_digit) begin
            accum_ff <= accum_next;
         end else begin
            accum_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && !is_digit) begin
         dvd_ff  <= accum_ff - AW'(1);
         zero_ff <= (accum_ff == '0);
         rem_ff  <= '0;
         mod_ff  <= RW'(eff_base - BW'(1));
         cnt_ff  <= NW'(AW - 1);
      end else if (ctrl.div_step) begin
         dvd_ff <= {dvd_ff[AW-2:0], 1'b0};
         rem_ff <= rem_next;
         cnt_ff <= cnt_ff - NW'(1);
         if (cnt_ff == '0) begin
            root_ff <= zero_ff ? '0 : rem_next + RW'(1);
         end
      end
   end

   // Bin valid bits and total count
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_valid_ff <= '0;
         total_ff     <= '0;
      end else if (ctrl.commit) begin
         bin_valid_ff[root_ff] <= 1'b1;
         total_ff              <= drh_pkg::sat_inc(total_ff);
      end
   end

   // Result output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         rsp_root_ff       <= root_ff;
         rsp_root_count_ff <= bin_new;
         rsp_total_ff      <= drh_pkg::sat_inc(total_ff);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.root        = rsp_root_ff;
   assign rsp_chan.root_count  = rsp_root_count_ff;
   assign rsp_chan.total_count = rsp_total_ff;

   // Configuration register
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= drh_pkg::BASE_RESET;
      end else if (csr_write && (paddr[2] == drh_pkg::REG_BASE_SIZE)) begin
         base_ff <= pwdata[BW-1:0];
      end
   end

   always_comb begin
      if (paddr[2] == drh_pkg::REG_BASE_SIZE) begin
         prdata = {{(drh_pkg::CSR_DATA_WIDTH-BW){1'b0}}, base_ff};
      end else begin
         prdata = '0;
      end
   end

endmodule
`default_nettype wire

// ----- design/drh_checker.sv -----
// Port-level checker for the digital root histogram top, bound to it.
`default_nettype none
`include "digital_root_histogram_top_assert.svh"
module drh_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_ready,
   input wire logic [drh_pkg::CHAR_WIDTH-1:0]   char_in,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [drh_pkg::ROOT_WIDTH-1:0]   root,
   input wire logic [drh_pkg::COUNT_WIDTH-1:0]  root_count,
   input wire logic [drh_pkg::COUNT_WIDTH-1:0]  total_count
);

   logic req_beat;
   logic delim;
   logic rsp_stall;
   logic [drh_pkg::ROOT_WIDTH+2*drh_pkg::COUNT_WIDTH-1:0] rsp_payload;

   assign req_beat    = req_valid && req_ready;
   assign delim       = (char_in < drh_pkg::CHAR_ZERO) || (char_in > drh_pkg::CHAR_NINE);
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {root, root_count, total_count};

   // A stalled result beat holds its payload
   `DRH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))
   // A bin can never count more numbers than the total
   `DRH_ASSERT_NOW(a_bin_le_total, clock, reset, rsp_valid, root_count <= total_count)
   // The root needs an iterative division: a delimiter closes the input next cycle
   `DRH_ASSERT_NEXT(a_busy_after_delim, clock, reset, req_beat && delim, !req_ready)
   // No result appears right after a beat taken with the output empty
   `DRH_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_beat && !rsp_valid, !rsp_valid)

endmodule

bind digital_root_histogram_top drh_checker u_drh_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .char_in     (req_chan.char_in),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .root        (rsp_chan.root),
   .root_count  (rsp_chan.root_count),
   .total_count (rsp_chan.total_count)
);
`default_nettype wire
